// ===== hw/rtl/plasma_pixel_color_generator_top_assert.svh =====
// Assertion macros shared by the plasma color generator modules.
`ifndef PLASMA_PIXEL_COLOR_GENERATOR_TOP_ASSERT_SVH
`define PLASMA_PIXEL_COLOR_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPCG_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPCG_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/ppcg_pkg.sv =====
// Shared constants, types and the sine table generator of the plasma color generator.
`timescale 1ns / 1ps

package ppcg_pkg;

    localparam int ANG_W     = 48;   // angles are Q.16 radians, kept modulo 2^48
    localparam int CFG_W     = 17;
    localparam int PHASE_W   = 16;
    localparam int SIN_W     = 18;   // signed Q1.16 sine sample
    localparam int SIN_MAG_W = 17;   // magnitude of a quarter-wave sample
    localparam int BASE_W    = 20;
    localparam int CH_W      = 21;
    localparam int W_W       = 19;
    localparam int PIX_W     = 32;
    localparam int K_W       = 30;

    // round(2^32 / 2pi), turns an angle into lookup steps.
    localparam logic [K_W-1:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    localparam logic [BASE_W-1:0] OFFSET_Q18 = 20'd104858;
    localparam logic [W_W-1:0]    ONE_Q18    = 19'd262144;
    localparam logic [7:0]        ALPHA      = 8'hFF;

    localparam int TAYLOR_TERMS = 10;
    localparam longint unsigned TAYLOR_DIV [1:9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};

    localparam logic [2:0] CFG_INV_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_INV_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_PHASE_RED  = 3'd2;
    localparam logic [2:0] CFG_PHASE_GRN  = 3'd3;
    localparam logic [2:0] CFG_PHASE_BLU  = 3'd4;

    typedef logic signed [SIN_W-1:0] t_sine;

    // Quarter-wave sample: Q30 Taylor series with truncated products, rounded to Q16.
    function automatic logic [SIN_MAG_W-1:0] quarter_sine(input longint unsigned idx,
                                                          input int unsigned log2_size);
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint          sum;
        a    = (idx * TWO_PI_Q30) >> log2_size;
        a2   = (a * a) >> 30;
        term = a;
        sum  = longint'(a);
        for (int k = 1; k < TAYLOR_TERMS; k++) begin
            term = ((term * a2) >> 30) / TAYLOR_DIV[k];
            if ((k & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 8192) >>> 14;
        if (sum > 65536) begin
            sum = 65536;
        end
        return SIN_MAG_W'(sum);
    endfunction

endpackage

// ===== hw/rtl/ppcg_delay.sv =====
// Enabled shift-register delay line for pipeline payload.
`timescale 1ns / 1ps

module ppcg_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_pipe[i] <= r_pipe[i-1];
            end
        end
    end

    assign o_data = r_pipe[DEPTH-1];

endmodule

// ===== hw/rtl/ppcg_sin_lut.sv =====
// Five-stage sine lookup: angle to table index, quarter-wave table read and sign.
`timescale 1ns / 1ps

module ppcg_sin_lut import ppcg_pkg::*; #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [ANG_W-1:0]                   i_angle,
    input  logic [$clog2(TABLE_SIZE)+6-1:0]    i_phase,
    output t_sine                              o_value
);

    localparam int L       = $clog2(TABLE_SIZE);
    localparam int PH_W    = L + 6;
    localparam int QUARTER = TABLE_SIZE / 4;
    localparam int ADDR_W  = L - 1;
    localparam int HALF    = ANG_W / 2;
    localparam int LO_W    = HALF + K_W;
    localparam logic [ADDR_W-1:0] QUARTER_A = ADDR_W'(QUARTER);

    logic [SIN_MAG_W-1:0] w_rom [QUARTER+1];

    for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_rom
        localparam logic [SIN_MAG_W-1:0] ENTRY = quarter_sine(gi, L);
        assign w_rom[gi] = ENTRY;
    end

    logic [LO_W-1:0]      w_hi_full;
    logic [ANG_W-1:0]     w_pos;
    logic [PH_W-1:0]      w_top;
    logic [1:0]           w_quad;
    logic [ADDR_W-1:0]    w_j;

    logic [LO_W-1:0]      r_lo;
    logic [HALF-1:0]      r_hi;
    logic [L-1:0]         r_idx;
    logic [ADDR_W-1:0]    r_addr;
    logic                 r_neg_a;
    logic [SIN_MAG_W-1:0] r_mag;
    logic                 r_neg_m;
    t_sine                r_val;

    // The angle times 1/2pi is only needed modulo 2^48, so the upper half
    // of the angle contributes just the low half of its partial product.
    assign w_hi_full = LO_W'(i_angle[ANG_W-1:HALF]) * LO_W'(INV_TWO_PI_Q32);
    assign w_pos     = ANG_W'(r_lo) + {r_hi, {HALF{1'b0}}};
    assign w_top     = w_pos[ANG_W-1 -: PH_W] + i_phase;
    assign w_quad    = r_idx[L-1 -: 2];
    assign w_j       = {1'b0, r_idx[L-3:0]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo    <= LO_W'(i_angle[HALF-1:0]) * LO_W'(INV_TWO_PI_Q32);
            r_hi    <= w_hi_full[HALF-1:0];
            r_idx   <= w_top[PH_W-1 -: L];
            r_addr  <= w_quad[0] ? (QUARTER_A - w_j) : w_j;
            r_neg_a <= w_quad[1];
            r_mag   <= w_rom[r_addr];
            r_neg_m <= r_neg_a;
            r_val   <= r_neg_m ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
        end
    end

    assign o_value = r_val;

endmodule

// ===== hw/rtl/ppcg_out_buf.sv =====
// Output register with a one-entry skid stage that decouples the pipeline from downstream stall.
`timescale 1ns / 1ps
`include "plasma_pixel_color_generator_top_assert.svh"

module ppcg_out_buf import ppcg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [PIX_W-1:0] o_data,
    input  logic             i_stall
);

    logic             r_out_valid;
    logic             r_skid_valid;
    logic [PIX_W-1:0] r_out_data;
    logic [PIX_W-1:0] r_skid_data;
    logic             w_take;
    logic             w_push;

    assign w_take = r_out_valid && !i_stall;
    assign w_push = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (w_push && r_out_valid && !w_take) begin
                r_skid_valid <= 1'b1;
            end
            if (w_take || !r_out_valid) begin
                r_out_valid <= r_skid_valid || w_push;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take || !r_out_valid) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end
        if (!r_skid_valid && w_push && r_out_valid && !w_take) begin
            r_skid_data <= i_data;
        end
    end

    // The pipeline freezes once the skid entry is occupied.
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    `PPCG_ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid entry held while output register is empty")
    `PPCG_ASSERT_NEXT(a_stalled_arrival_kept, i_clk, i_rst_n, w_push && r_out_valid && i_stall, r_skid_valid && r_out_valid, "transfer arriving under stall was not parked in the skid entry")

endmodule

// ===== hw/rtl/plasma_pixel_color_generator_top.sv =====
// Throughput: one pixel per cycle while the enable is high; seventeen register stages run on
// one shared enable. The enable drops only while the skid entry behind the output register
// is occupied.
// Reset (synchronous, active low) clears all valid bits and loads the default registers.
// The sine table is constant logic, so no fill or clearing pass follows reset.
`timescale 1ns / 1ps
`include "plasma_pixel_color_generator_top_assert.svh"

module plasma_pixel_color_generator_top import ppcg_pkg::*; #(
    parameter int TABLE_SIZE = 1024,
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_pixel_abgr,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int NSTAGE = 17;
    localparam int PH_W   = $clog2(TABLE_SIZE) + 6;
    localparam int XR_W   = COORD_BITS + CFG_W;
    localparam int SQ_W   = 2 * XR_W;
    localparam logic [PH_W-1:0] COS_PHASE = PH_W'(TABLE_SIZE / 4) << 6;

    function automatic logic [W_W-1:0] clamp_unit(input logic signed [CH_W-1:0] v);
        if (v[CH_W-1]) begin
            return '0;
        end else if (v > $signed({2'b00, ONE_Q18})) begin
            return ONE_Q18;
        end
        return v[W_W-1:0];
    endfunction

    function automatic logic [7:0] scale255(input logic [W_W-1:0] w);
        logic [W_W+7:0] p;
        p = {w, 8'd0} - {8'd0, w};
        return p[W_W+6 -: 8];
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0]   r_inv_width;
    logic [CFG_W-1:0]   r_inv_height;
    logic [PHASE_W-1:0] r_phase_red;
    logic [PHASE_W-1:0] r_phase_grn;
    logic [PHASE_W-1:0] r_phase_blu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_width  <= CFG_W'(102);
            r_inv_height <= CFG_W'(137);
            r_phase_red  <= '0;
            r_phase_grn  <= '0;
            r_phase_blu  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INV_WIDTH:  r_inv_width  <= i_cfg_data;
                CFG_INV_HEIGHT: r_inv_height <= i_cfg_data;
                CFG_PHASE_RED:  r_phase_red  <= i_cfg_data[PHASE_W-1:0];
                CFG_PHASE_GRN:  r_phase_grn  <= i_cfg_data[PHASE_W-1:0];
                CFG_PHASE_BLU:  r_phase_blu  <= i_cfg_data[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic [NSTAGE:1] r_vld;

    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTAGE-1:1], i_in_valid};
        end
    end

    logic [XR_W-1:0]   r1_xr;
    logic [XR_W-1:0]   r1_yr;
    logic [XR_W:0]     w_xy_sum;
    logic [ANG_W-1:0]  w_xy_ext;
    logic [ANG_W-1:0]  w_x_ext;
    logic [ANG_W-1:0]  w_y_ext;
    logic [ANG_W-1:0]  r2_a1;
    logic [ANG_W-1:0]  r2_a3;
    logic [ANG_W-1:0]  r2_a5;
    logic [SQ_W-1:0]   r2_xsq;
    logic [SQ_W-1:0]   r2_ysq;
    logic [ANG_W-1:0]  r2_x10;
    logic [ANG_W-1:0]  r2_y5;
    logic [ANG_W-1:0]  r3_a1;
    logic [ANG_W-1:0]  r3_a3;
    logic [ANG_W-1:0]  r3_a4;
    logic [ANG_W-1:0]  r3_a5;
    logic [ANG_W-1:0]  w8_x10;
    logic [ANG_W-1:0]  w8_y5;
    t_sine             w8_s1;
    t_sine             w8_t2;
    t_sine             w8_t3;
    t_sine             w8_yc;
    logic [ANG_W-1:0]  r9_a2;
    logic [ANG_W-1:0]  r9_a6;
    logic [SIN_W:0]    r9_t23;
    logic [SIN_W:0]    w14_t23;
    t_sine             w14_t1;
    t_sine             w14_red;
    t_sine             w14_grn;
    t_sine             w14_blu;
    logic [BASE_W-1:0] r15_base;
    t_sine             r15_red;
    t_sine             r15_grn;
    t_sine             r15_blu;
    logic [W_W-1:0]    r16_w_red;
    logic [W_W-1:0]    r16_w_grn;
    logic [W_W-1:0]    r16_w_blu;
    logic [PIX_W-1:0]  r17_abgr;

    assign w_xy_sum = {1'b0, r1_xr} + {1'b0, r1_yr};
    assign w_xy_ext = ANG_W'(w_xy_sum);
    assign w_x_ext  = ANG_W'(r1_xr);
    assign w_y_ext  = ANG_W'(r1_yr);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // Stage 1: coordinates to Q.16 ratios.
            r1_xr  <= XR_W'(i_pixel_x) * XR_W'(r_inv_width);
            r1_yr  <= XR_W'(i_pixel_y) * XR_W'(r_inv_height);
            // Stage 2: constant scalings by shift and add, and the two squares.
            r2_a1  <= (w_x_ext << 5) - (w_x_ext << 1);
            r2_a3  <= (w_xy_ext << 4) + (w_xy_ext << 3) + w_xy_ext;
            r2_a5  <= (w_y_ext << 4) + (w_y_ext << 2);
            r2_xsq <= SQ_W'(r1_xr) * SQ_W'(r1_xr);
            r2_ysq <= SQ_W'(r1_yr) * SQ_W'(r1_yr);
            r2_x10 <= (w_x_ext << 3) + (w_x_ext << 1);
            r2_y5  <= (w_y_ext << 2) + w_y_ext;
            // Stage 3: radial term.
            r3_a1  <= r2_a1;
            r3_a3  <= r2_a3;
            r3_a5  <= r2_a5;
            r3_a4  <= ANG_W'(r2_xsq[SQ_W-1:16]) + ANG_W'(r2_ysq[SQ_W-1:16]);
            // Stage 9: angles that depend on a first lookup.
            r9_a2  <= w8_y5 + {{(ANG_W-SIN_W){w8_s1[SIN_W-1]}}, w8_s1};
            r9_a6  <= w8_x10 + {{(ANG_W-SIN_W){w8_yc[SIN_W-1]}}, w8_yc};
            r9_t23 <= {w8_t2[SIN_W-1], w8_t2} + {w8_t3[SIN_W-1], w8_t3};
            // Stage 15: shared base term with the 0.4 offset folded in.
            r15_base <= {{(BASE_W-SIN_W){w14_t1[SIN_W-1]}}, w14_t1}
                      + {w14_t23[SIN_W], w14_t23} + OFFSET_Q18;
            r15_red  <= w14_red;
            r15_grn  <= w14_grn;
            r15_blu  <= w14_blu;
            // Stage 16: per-channel clamp to the unit interval.
            r16_w_red <= clamp_unit({{(CH_W-SIN_W){r15_red[SIN_W-1]}}, r15_red}
                                    + {r15_base[BASE_W-1], r15_base});
            r16_w_grn <= clamp_unit({{(CH_W-SIN_W){r15_grn[SIN_W-1]}}, r15_grn}
                                    + {r15_base[BASE_W-1], r15_base});
            r16_w_blu <= clamp_unit({{(CH_W-SIN_W){r15_blu[SIN_W-1]}}, r15_blu}
                                    + {r15_base[BASE_W-1], r15_base});
            // Stage 17: scale to eight bits and pack.
            r17_abgr <= {ALPHA, scale255(r16_w_blu), scale255(r16_w_grn),
                         scale255(r16_w_red)};
        end
    end

    ppcg_delay #(.WIDTH(2 * ANG_W), .DEPTH(6)) u_dly_lin (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data ({r2_x10, r2_y5}),
        .o_data ({w8_x10, w8_y5})
    );

    ppcg_delay #(.WIDTH(SIN_W + 1), .DEPTH(5)) u_dly_t23 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (r9_t23),
        .o_data (w14_t23)
    );

    // First lookup wave, stages 4 to 8.
    ppcg_sin_lut #(.TABLE_SIZE(TABLE_SIZE)) u_sin_s1 (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r3_a1), .i_phase('0), .o_value(w8_s1)
    );
    ppcg_sin_lut #(.TABLE_SIZE(TABLE_SIZE)) u_sin_t2 (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r3_a3), .i_phase('0), .o_value(w8_t2)
    );
    ppcg_sin_lut #(.TABLE_SIZE(TABLE_SIZE)) u_sin_t3 (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r3_a4), .i_phase('0), .o_value(w8_t3)
    );
    // Cosine reads a quarter turn further along the same table.
    ppcg_sin_lut #(.TABLE_SIZE(TABLE_SIZE)) u_sin_yc (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r3_a5), .i_phase(COS_PHASE),
        .o_value(w8_yc)
    );

    // Second lookup wave, stages 10 to 14.
    ppcg_sin_lut #(.TABLE_SIZE(TABLE_SIZE)) u_sin_t1 (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r9_a2), .i_phase('0), .o_value(w14_t1)
    );
    ppcg_sin_lut #(.TABLE_SIZE(TABLE_SIZE)) u_sin_red (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r9_a6), .i_phase(PH_W'(r_phase_red)),
        .o_value(w14_red)
    );
    ppcg_sin_lut #(.TABLE_SIZE(TABLE_SIZE)) u_sin_grn (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r9_a6), .i_phase(PH_W'(r_phase_grn)),
        .o_value(w14_grn)
    );
    ppcg_sin_lut #(.TABLE_SIZE(TABLE_SIZE)) u_sin_blu (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r9_a6), .i_phase(PH_W'(r_phase_blu)),
        .o_value(w14_blu)
    );

    ppcg_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[NSTAGE]),
        .i_data  (r17_abgr),
        .o_ready (w_en),
        .o_valid (o_out_valid),
        .o_data  (o_pixel_abgr),
        .i_stall (i_out_stall)
    );

    `PPCG_ASSERT_IMPLY(a_alpha_opaque, i_clk, i_rst_n, o_out_valid,
        o_pixel_abgr[PIX_W-1 -: 8] == ALPHA, "result transfer without opaque alpha")
    `PPCG_ASSERT_IMPLY(a_channel_clamped, i_clk, i_rst_n, r_vld[NSTAGE-1],
        (r16_w_red <= ONE_Q18) && (r16_w_grn <= ONE_Q18) && (r16_w_blu <= ONE_Q18),
        "channel value above one after clamp")

endmodule

// ===== tb/tb_plasma_pixel_color_generator_top.sv =====
// Self-checking testbench for the plasma pixel color generator with its own color predictor.
`timescale 1ns / 1ps

module tb_plasma_pixel_color_generator_top;
    import ppcg_pkg::*;

    localparam int TBL_SIZE    = 1024;
    localparam int COORD_W     = 12;
    localparam int LATENCY     = 17;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 10;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 170;
    localparam int IDX_SPACE   = 1 << 3;

    localparam int unsigned RECIP_MAX       = 65536;
    localparam int unsigned PHASE_MAX       = 65535;
    localparam int unsigned INV_WIDTH_INIT  = 102;
    localparam int unsigned INV_HEIGHT_INIT = 137;
    localparam int unsigned COORD_MAX       = (1 << COORD_W) - 1;

    // 2pi in Q30 radians, and lookup steps per radian in Q32.
    localparam bit [63:0] RAD_Q30_TURN   = 64'd6746518852;
    localparam bit [63:0] TURN_STEPS_Q32 = 64'd683565276;
    localparam longint    LEVEL_OFFSET   = 104858;
    localparam longint    LEVEL_ONE      = 262144;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } coord_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [COORD_W-1:0]    i_pixel_x   = '0;
    logic [COORD_W-1:0]    i_pixel_y   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [2:0]            i_cfg_idx   = '0;
    logic [CFG_W-1:0]      i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [PIX_W-1:0]      o_pixel_abgr;

    coord_t                pending_pixels [$];
    logic [PIX_W-1:0]      pending_colors [$];
    int                    sine_rom [TBL_SIZE];

    int unsigned           inv_w;
    int unsigned           inv_h;
    int unsigned           phase_r;
    int unsigned           phase_g;
    int unsigned           phase_b;

    int unsigned           src_gap_pct    = 36;
    int unsigned           sink_stall_pct = 68;
    logic                  in_taken       = 1'b0;
    int                    err_count      = 0;
    int                    cycle_count    = 0;
    coord_t                drv_pixel;
    logic [PIX_W-1:0]      want_color;

    plasma_pixel_color_generator_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_abgr (o_pixel_abgr),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // First quadrant sample: truncated Q30 Taylor series, rounded half up to Q16.
    function automatic int quarter_wave(int unsigned step);
        bit [63:0] ang;
        bit [63:0] ang_sq;
        bit [63:0] term;
        longint    acc;
        ang    = (64'(step) * RAD_Q30_TURN) / 64'(TBL_SIZE);
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        for (int k = 1; k < 10; k++) begin
            term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + 8192) >>> 14;
        if (acc > 65536) begin
            acc = 65536;
        end
        return int'(acc);
    endfunction

    // Angle is Q.16 radians modulo 2^64; the phase is Q10.6 lookup steps.
    function automatic int step_index(bit [63:0] ang, bit [63:0] phase_q6);
        bit [63:0] pos;
        pos = ang * 64'(TBL_SIZE) * TURN_STEPS_Q32 + (phase_q6 << 42);
        return int'((pos >> 48) & 64'(TBL_SIZE - 1));
    endfunction

    function automatic logic [7:0] channel_level(int s, int base);
        longint w;
        w = longint'(s) + longint'(base) + LEVEL_OFFSET;
        if (w < 0) begin
            w = 0;
        end
        if (w > LEVEL_ONE) begin
            w = LEVEL_ONE;
        end
        return 8'((w * 255) >>> 18);
    endfunction

    function automatic logic [PIX_W-1:0] plasma_color(logic [COORD_W-1:0] px,
                                                      logic [COORD_W-1:0] py);
        bit [63:0] xr;
        bit [63:0] yr;
        bit [63:0] swirl;
        bit [63:0] ang;
        int        base;
        int        y_cos;
        xr    = 64'(px) * 64'(inv_w);
        yr    = 64'(py) * 64'(inv_h);
        // Sine results feed back into angles sign-extended, so angles may go negative.
        swirl = 64'(longint'(sine_rom[step_index(xr * 64'd30, 64'd0)]));
        base  = sine_rom[step_index(yr * 64'd5 + swirl, 64'd0)]
              + sine_rom[step_index((xr + yr) * 64'd25, 64'd0)]
              + sine_rom[step_index(((xr * xr) >> 16) + ((yr * yr) >> 16), 64'd0)];
        y_cos = sine_rom[(step_index(yr * 64'd20, 64'd0) + TBL_SIZE / 4) % TBL_SIZE];
        ang   = xr * 64'd10 + 64'(longint'(y_cos));
        return {ALPHA,
                channel_level(sine_rom[step_index(ang, 64'(phase_b))], base),
                channel_level(sine_rom[step_index(ang, 64'(phase_g))], base),
                channel_level(sine_rom[step_index(ang, 64'(phase_r))], base)};
    endfunction

    task automatic note_mismatch(input string what, input logic [PIX_W-1:0] want,
                                 input logic [PIX_W-1:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("[%0t] %s: expected %08h, got %08h", $realtime, what, want, got);
        end
    endtask

    // Input side: a new pixel is offered only when no transfer is pending.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);
        if (!i_in_valid || in_taken) begin
            if (i_rst_n && pending_pixels.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
                drv_pixel = pending_pixels.pop_front();
                i_in_valid <= 1'b1;
                i_pixel_x  <= drv_pixel.x;
                i_pixel_y  <= drv_pixel.y;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Register copy, prediction on input transfers and checking of output transfers.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && (o_in_stall === 1'b0);
        if (!i_rst_n) begin
            inv_w   = INV_WIDTH_INIT;
            inv_h   = INV_HEIGHT_INIT;
            phase_r = 0;
            phase_g = 0;
            phase_b = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INV_WIDTH:  inv_w   = 32'(i_cfg_data);
                    CFG_INV_HEIGHT: inv_h   = 32'(i_cfg_data);
                    CFG_PHASE_RED:  phase_r = 32'(i_cfg_data[PHASE_W-1:0]);
                    CFG_PHASE_GRN:  phase_g = 32'(i_cfg_data[PHASE_W-1:0]);
                    CFG_PHASE_BLU:  phase_b = 32'(i_cfg_data[PHASE_W-1:0]);
                    default: ;
                endcase
            end
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (pending_colors.size() == 0) begin
                    note_mismatch("unexpected pixel_abgr", '0, o_pixel_abgr);
                end else begin
                    want_color = pending_colors.pop_front();
                    if (o_pixel_abgr !== want_color) begin
                        note_mismatch("pixel_abgr mismatch", want_color, o_pixel_abgr);
                    end
                end
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                pending_colors.push_back(plasma_color(i_pixel_x, i_pixel_y));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_pixel(input int unsigned x, input int unsigned y);
        pending_pixels.push_back({COORD_W'(x), COORD_W'(y)});
    endtask

    // Returns once every queued pixel has been transferred and its color checked.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (pending_pixels.size() != 0 || i_in_valid || pending_colors.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic int unsigned pick_recip();
        case ($urandom_range(7))
            0: return 0;
            1: return RECIP_MAX;
            2: return RECIP_MAX / $urandom_range(COORD_MAX + 1, 1);
            default: return $urandom_range(RECIP_MAX, 0);
        endcase
    endfunction

    function automatic int unsigned pick_phase();
        case ($urandom_range(7))
            0: return 0;
            1: return PHASE_MAX;
            default: return $urandom_range(PHASE_MAX, 0);
        endcase
    endfunction

    initial begin
        for (int i = 0; i < TBL_SIZE; i++) begin
            if (i <= TBL_SIZE / 4) begin
                sine_rom[i] = quarter_wave(i);
            end else if (i <= TBL_SIZE / 2) begin
                sine_rom[i] = quarter_wave(TBL_SIZE / 2 - i);
            end else if (i <= 3 * TBL_SIZE / 4) begin
                sine_rom[i] = -quarter_wave(i - TBL_SIZE / 2);
            end else begin
                sine_rom[i] = -quarter_wave(TBL_SIZE - i);
            end
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults, coordinate extremes, and pixels whose inner sine or
        // cosine term is negative so that the following angle wraps below zero.
        queue_pixel(0, 0);
        queue_pixel(COORD_MAX, COORD_MAX);
        queue_pixel(0, COORD_MAX);
        queue_pixel(COORD_MAX, 0);
        queue_pixel(1, 1);
        queue_pixel(2048, 2048);
        queue_pixel(100, 0);
        queue_pixel(0, 75);
        wait_drained();

        // Writes to unused register indexes must leave the defaults intact.
        for (int k = CFG_PHASE_BLU + 1; k < IDX_SPACE; k++) begin
            write_reg(3'(k), $urandom_range(RECIP_MAX, 0));
        end
        queue_pixel(COORD_MAX, COORD_MAX);
        queue_pixel(123, 3000);
        wait_drained();

        // Zero reciprocals give one constant color.
        write_reg(CFG_INV_WIDTH, 0);
        write_reg(CFG_INV_HEIGHT, 0);
        write_reg(CFG_PHASE_RED, 0);
        write_reg(CFG_PHASE_GRN, PHASE_MAX);
        write_reg(CFG_PHASE_BLU, 32768);
        queue_pixel(0, 0);
        queue_pixel(COORD_MAX, COORD_MAX);
        queue_pixel(1234, 567);
        wait_drained();

        // Ratios of one: the coordinates go unscaled and the angles wrap.
        write_reg(CFG_INV_WIDTH, RECIP_MAX);
        write_reg(CFG_INV_HEIGHT, RECIP_MAX);
        write_reg(CFG_PHASE_RED, PHASE_MAX);
        write_reg(CFG_PHASE_GRN, PHASE_MAX);
        write_reg(CFG_PHASE_BLU, PHASE_MAX);
        queue_pixel(0, 0);
        queue_pixel(COORD_MAX, COORD_MAX);
        queue_pixel(COORD_MAX, 0);
        queue_pixel(0, COORD_MAX);
        queue_pixel(2730, 1365);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < RAND_PHASES / 3) begin
                src_gap_pct    = 36;
                sink_stall_pct = 68;
            end else if (p < 2 * RAND_PHASES / 3) begin
                src_gap_pct    = 68;
                sink_stall_pct = 36;
            end else begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            write_reg(CFG_INV_WIDTH, pick_recip());
            write_reg(CFG_INV_HEIGHT, pick_recip());
            write_reg(CFG_PHASE_RED, pick_phase());
            write_reg(CFG_PHASE_GRN, pick_phase());
            write_reg(CFG_PHASE_BLU, pick_phase());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                queue_pixel($urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0));
                // Hold off the sender halfway until the pipeline has emptied.
                if (n == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        repeat (LATENCY + 20) @(posedge i_clk);
        if (err_count == 0 && pending_colors.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
